/* hw/rtl/top_k_maximum_tracker_assert.svh */
// assertion macros for the top-k maximum tracker
`ifndef TOP_K_MAXIMUM_TRACKER_ASSERT_SVH
`define TOP_K_MAXIMUM_TRACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TKM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tkm assertion failed");

// next-cycle implication, checked outside reset
`define TKM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tkm assertion failed");

`endif

/* hw/rtl/tkm_pkg.sv */
// shared types, constants and sample decode functions of the top-k maximum tracker
`default_nettype none
package tkm_pkg;

    localparam int MaxKeepDef   = 16;
    localparam int CoordBitsDef = 20;
    localparam int CoordW       = 20;
    localparam int CoordExtW    = 31;
    localparam int ValueW       = 33;
    localparam int KeepW        = 5;
    localparam int FmtW         = 3;
    localparam int RankW        = 4;
    localparam int CfgDataW     = 5;
    localparam int InDataW      = 80;
    localparam int OutDataW     = 80;

    localparam logic [FmtW-1:0] FMT_U8  = 3'd0;
    localparam logic [FmtW-1:0] FMT_S8  = 3'd1;
    localparam logic [FmtW-1:0] FMT_U16 = 3'd2;
    localparam logic [FmtW-1:0] FMT_S16 = 3'd3;
    localparam logic [FmtW-1:0] FMT_U32 = 3'd4;

    localparam logic REG_KEEP_COUNT    = 1'b0;
    localparam logic REG_SAMPLE_FORMAT = 1'b1;

    typedef logic signed [ValueW-1:0] t_value;

    typedef struct packed {
        logic insert;
        logic full;
        logic shift;
    } t_cell_ctl;

    function automatic t_value decode_sample(input logic [ValueW-1:0] raw,
                                             input logic [FmtW-1:0] fmt);
        t_value v;
        unique case (fmt)
            FMT_U8:  v = {25'd0, raw[7:0]};
            FMT_S8:  v = {{25{raw[7]}}, raw[7:0]};
            FMT_U16: v = {17'd0, raw[15:0]};
            FMT_S16: v = {{17{raw[15]}}, raw[15:0]};
            FMT_U32: v = {1'b0, raw[31:0]};
            default: v = {raw[31], raw[31:0]};
        endcase
        return v;
    endfunction

    function automatic t_value ceiling_of(input logic [FmtW-1:0] fmt);
        t_value c;
        unique case (fmt)
            FMT_U8:  c = 33'sd255;
            FMT_S8:  c = 33'sd127;
            FMT_U16: c = 33'sd65535;
            FMT_S16: c = 33'sd32767;
            FMT_U32: c = 33'sd4294967295;
            default: c = 33'sd2147483647;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/tkm_cell.sv */
// one cell of the sorted keep chain: holds an entry, compares, shifts or takes the new word
`default_nettype none
module tkm_cell #(
    parameter int COORD_BITS = tkm_pkg::CoordBitsDef
) (
    input  logic                    i_clk,
    input  tkm_pkg::t_cell_ctl      i_ctl,
    input  logic                    i_occupied,
    input  tkm_pkg::t_value         i_new_value,
    input  logic [2*COORD_BITS-1:0] i_new_pos,
    input  logic                    i_prev_le,
    input  tkm_pkg::t_value         i_prev_value,
    input  logic [2*COORD_BITS-1:0] i_prev_pos,
    input  logic                    i_next_le,
    input  tkm_pkg::t_value         i_next_value,
    input  logic [2*COORD_BITS-1:0] i_next_pos,
    output logic                    o_le,
    output tkm_pkg::t_value         o_value,
    output logic [2*COORD_BITS-1:0] o_pos
);
    import tkm_pkg::*;

    t_value                  r_value;
    t_value                  n_value;
    logic [2*COORD_BITS-1:0] r_pos;
    logic [2*COORD_BITS-1:0] n_pos;

    assign o_le    = i_occupied && (r_value <= i_new_value);
    assign o_value = r_value;
    assign o_pos   = r_pos;

    always_comb begin
        n_value = r_value;
        n_pos   = r_pos;
        if (i_ctl.shift) begin
            n_value = i_next_value;
            n_pos   = i_next_pos;
        end else if (i_ctl.insert) begin
            if (i_ctl.full) begin
                // drop the smallest, slide lower entries down
                if (o_le) begin
                    if (i_next_le) begin
                        n_value = i_next_value;
                        n_pos   = i_next_pos;
                    end else begin
                        n_value = i_new_value;
                        n_pos   = i_new_pos;
                    end
                end
            end else if (!o_le) begin
                // open a slot, slide upper entries up
                if (i_prev_le) begin
                    n_value = i_new_value;
                    n_pos   = i_new_pos;
                end else begin
                    n_value = i_prev_value;
                    n_pos   = i_prev_pos;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_pos   <= n_pos;
    end

endmodule
`default_nettype wire

/* hw/rtl/top_k_maximum_tracker.sv */
// top level of the top-k maximum tracker: config registers, cell chain and dump control
//
// input stream: one word per sample (value, column, row in tdata, tlast marks the
// last sample of an image). each accepted word is sorted into a chain of MAX_KEEP
// cells, so samples are taken one per cycle while no dump runs.
// once the kept minimum of a full chain reaches the format ceiling, samples are
// dropped until tlast.
// on a word with tlast the sample is inserted first, then the kept entries are sent
// on the output stream from smallest to largest, one per cycle while the receiver
// is ready, the first one in the cycle after the tlast word; tlast marks the overall
// maximum. an image with nothing kept gives one word with tuser low. during the
// dump tready on the input stays low; a stalled receiver simply holds the current
// word, the chain shifts only on acceptance. config writes (keep_count, sample_format)
// empty the chain; the user must make them while idle, the block does not enforce it.
// reset empties the chain and sets keep_count 1, sample_format u8.
`default_nettype none
module top_k_maximum_tracker #(
    parameter int MAX_KEEP   = tkm_pkg::MaxKeepDef,
    parameter int COORD_BITS = tkm_pkg::CoordBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_addr,
    input  logic [tkm_pkg::CfgDataW-1:0]  i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // sample[32:0], pixel_col[52:33], pixel_row[72:53], zero pad
    input  logic [tkm_pkg::InDataW-1:0]   i_s_tdata,
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // kept_value[32:0], kept_col[52:33], kept_row[72:53], rank[76:73], zero pad
    output logic [tkm_pkg::OutDataW-1:0]  o_m_tdata,
    // entry_valid
    output logic                          o_m_tuser,
    output logic                          o_m_tlast
);
    import tkm_pkg::*;

    localparam int CNT_W = $clog2(MAX_KEEP + 1);
    localparam int CW    = (CNT_W > KeepW) ? CNT_W : KeepW;
    localparam int PW    = 2 * COORD_BITS;

    logic [KeepW-1:0] r_keep;
    logic [FmtW-1:0]  r_fmt;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] r_rank;
    logic [CNT_W-1:0] n_rank;
    logic             r_dump;
    logic             n_dump;

    logic [CW-1:0]    w_keep_ext;
    logic [CW-1:0]    w_keep_eff;
    logic             w_full;
    logic             w_halted;
    logic             w_in_take;
    logic             w_out_take;
    logic             w_empty;
    logic             w_final;
    t_value           w_new_value;
    logic [PW-1:0]    w_new_pos;
    logic [CoordExtW-1:0] w_col_ext;
    logic [CoordExtW-1:0] w_row_ext;
    logic [CoordExtW-1:0] w_out_col;
    logic [CoordExtW-1:0] w_out_row;
    logic [CoordExtW-1:0] w_rank_ext;
    t_cell_ctl        w_ctl;

    t_value           w_value [MAX_KEEP];
    logic [PW-1:0]    w_pos   [MAX_KEEP];
    logic [MAX_KEEP-1:0] w_le;

    // effective keep count, clamped to 1..MAX_KEEP
    assign w_keep_ext = CW'(r_keep);
    always_comb begin
        if (r_keep == '0) begin
            w_keep_eff = CW'(1);
        end else if (w_keep_ext > CW'(MAX_KEEP)) begin
            w_keep_eff = CW'(MAX_KEEP);
        end else begin
            w_keep_eff = w_keep_ext;
        end
    end

    assign w_full   = CW'(r_fill) >= w_keep_eff;
    assign w_halted = w_full && (w_value[0] >= ceiling_of(r_fmt));

    assign o_s_tready = !r_dump;
    assign w_in_take  = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_dump;
    assign w_out_take = r_dump && i_m_tready;

    assign w_new_value = decode_sample(i_s_tdata[ValueW-1:0], r_fmt);
    assign w_col_ext   = CoordExtW'(i_s_tdata[ValueW +: CoordW]);
    assign w_row_ext   = CoordExtW'(i_s_tdata[ValueW+CoordW +: CoordW]);
    assign w_new_pos   = {w_row_ext[COORD_BITS-1:0], w_col_ext[COORD_BITS-1:0]};

    assign w_ctl.insert = w_in_take && !w_halted;
    assign w_ctl.full   = w_full;
    assign w_ctl.shift  = w_out_take;

    genvar g;
    generate
        for (g = 0; g < MAX_KEEP; g++) begin : g_cell
            localparam int PREV = (g == 0) ? 0 : g - 1;
            localparam int NEXT = (g == MAX_KEEP - 1) ? g : g + 1;
            tkm_cell #(
                .COORD_BITS (COORD_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_occupied   (r_fill > CNT_W'(g)),
                .i_new_value  (w_new_value),
                .i_new_pos    (w_new_pos),
                .i_prev_le    ((g == 0) ? 1'b1 : w_le[PREV]),
                .i_prev_value (w_value[PREV]),
                .i_prev_pos   (w_pos[PREV]),
                .i_next_le    ((g == MAX_KEEP - 1) ? 1'b0 : w_le[NEXT]),
                .i_next_value (w_value[NEXT]),
                .i_next_pos   (w_pos[NEXT]),
                .o_le         (w_le[g]),
                .o_value      (w_value[g]),
                .o_pos        (w_pos[g])
            );
        end
    endgenerate

    // dump output from the head cell
    assign w_empty    = (r_fill == '0);
    assign w_final    = w_empty || (({1'b0, r_rank} + 1'b1) == {1'b0, r_fill});
    assign w_out_col  = CoordExtW'(w_pos[0][COORD_BITS-1:0]);
    assign w_out_row  = CoordExtW'(w_pos[0][PW-1:COORD_BITS]);
    assign w_rank_ext = CoordExtW'(r_rank);

    always_comb begin
        o_m_tdata = '0;
        if (!w_empty) begin
            o_m_tdata[ValueW-1:0]                   = w_value[0];
            o_m_tdata[ValueW +: CoordW]             = w_out_col[CoordW-1:0];
            o_m_tdata[ValueW+CoordW +: CoordW]      = w_out_row[CoordW-1:0];
            o_m_tdata[ValueW+2*CoordW +: RankW]     = w_rank_ext[RankW-1:0];
        end
    end
    assign o_m_tuser = !w_empty;
    assign o_m_tlast = w_final;

    always_comb begin
        n_fill = r_fill;
        n_rank = r_rank;
        n_dump = r_dump;
        if (i_cfg_we) begin
            n_fill = '0;
        end else if (w_out_take) begin
            if (w_final) begin
                n_fill = '0;
                n_dump = 1'b0;
            end else begin
                n_rank = r_rank + 1'b1;
            end
        end else if (w_in_take) begin
            if (w_ctl.insert && !w_full) begin
                n_fill = r_fill + 1'b1;
            end
            if (i_s_tlast) begin
                n_dump = 1'b1;
                n_rank = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KeepW'(1);
            r_fmt  <= FMT_U8;
            r_fill <= '0;
            r_rank <= '0;
            r_dump <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_rank <= n_rank;
            r_dump <= n_dump;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_KEEP_COUNT:    r_keep <= i_cfg_wdata[KeepW-1:0];
                    REG_SAMPLE_FORMAT: r_fmt  <= i_cfg_wdata[FmtW-1:0];
                    default:           r_keep <= r_keep;
                endcase
            end
        end
    end

`include "top_k_maximum_tracker_assert.svh"

    `TKM_ASSERT_SAME(a_fill_bound, 1'b1, CW'(r_fill) <= w_keep_eff)
    `TKM_ASSERT_NEXT(a_dump_start, w_in_take && i_s_tlast && !i_cfg_we, r_dump && (r_rank == '0))
    `TKM_ASSERT_NEXT(a_dump_end, w_out_take && w_final, !r_dump && (r_fill == '0))

    // the chain shifts down during a dump, so order holds only outside it
    generate
        for (g = 0; g + 1 < MAX_KEEP; g++) begin : g_order
            `TKM_ASSERT_SAME(a_sorted, !r_dump && (r_fill > CNT_W'(g + 1)), w_value[g] <= w_value[g + 1])
        end
    endgenerate

endmodule
`default_nettype wire
